// ===== rtl/gbn_pkg.sv =====
// Package for the go-back-n sender: sizes, codes, item structs and slot arithmetic.
// No dependencies; imported by gbn_csum and go_back_n_sender_core.
`default_nettype none
package gbn_pkg;

    localparam int WINDOW   = 8;
    localparam int SEQ_BITS = 16;

    localparam int    SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int    CNT_W   = $clog2(WINDOW + 1);
    localparam longint SEQ_MAX = (longint'(1) << SEQ_BITS) - 1;
    localparam int    WIN_CAP = (longint'(WINDOW) < SEQ_MAX) ? WINDOW : int'(SEQ_MAX);

    localparam int WIN_W     = 4;
    localparam int TMO_W     = 16;
    localparam int CMP_W     = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam int SUM_W      = 32;
    localparam int PAY_W      = 160;
    localparam int LANE_BYTES = SUM_W / 8;
    localparam int CSUM_STEPS = PAY_W / SUM_W;
    localparam int STEP_W     = $clog2(CSUM_STEPS);

    localparam logic [1:0] KIND_MSG  = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_RETX    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);

    localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(8);
    localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(20);

    typedef logic [SEQ_BITS-1:0] t_seq;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef struct packed {
        logic [1:0]        kind;
        logic [63:0]       payload_lo;
        logic [63:0]       payload_mid;
        logic [31:0]       payload_hi;
        logic [15:0]       pkt_seq;
        logic [15:0]       pkt_ack;
        logic signed [31:0] pkt_checksum;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        seq_num;
        logic [15:0]        ack_num;
        logic signed [31:0] sum_field;
        logic [63:0]        out_payload_lo;
        logic [63:0]        out_payload_mid;
        logic [31:0]        out_payload_hi;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] init;
        logic [PAY_W-1:0] data;
    } t_csum_req;

    // a < WINDOW and b <= WINDOW, so one conditional subtract wraps the slot
    function automatic t_slot slot_add(t_slot a, t_cnt b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(WINDOW)) begin
            s = s - (CNT_W + 1)'(WINDOW);
        end
        return SLOT_W'(s);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gbn_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 8
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/gbn_csum.sv =====
// Iterative packet checksum: one 32-bit lane of signed bytes added per cycle.
// Depends on gbn_pkg.
`default_nettype none
module gbn_csum (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire gbn_pkg::t_csum_req      i_req,
    output logic                         o_done,
    output logic [gbn_pkg::SUM_W-1:0]    o_sum
);
    import gbn_pkg::*;

    logic [SUM_W-1:0]  r_acc;
    logic [PAY_W-1:0]  r_data;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [SUM_W-1:0]  w_lane;

    always_comb begin
        w_lane = r_acc;
        for (int k = 0; k < LANE_BYTES; k++) begin
            w_lane = w_lane + {{(SUM_W - 8){r_data[8 * k + 7]}}, r_data[8 * k +: 8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(CSUM_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= i_req.init;
            r_data <= i_req.data;
        end else if (r_busy) begin
            r_acc  <= w_lane;
            r_data <= r_data >> SUM_W;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule
`default_nettype wire

// ===== rtl/go_back_n_sender_core.sv =====
// Go-back-N ARQ sender top level: window control, timer, retransmission sequencer.
// Depends on gbn_pkg, gbn_ram and gbn_csum.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//   cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// Message: checksum over 5 lane steps, then the result is loaded; ack: 5 lane steps, no result.
// Tick at expiry: each resent packet takes a RAM read, 5 lane steps and a load.
// Refused message: goes straight to the load state; other ticks and ignored kinds stay idle, no result.
// All checksums go through the single checksum unit.
// Reset is synchronous and clears window, timer and control registers to defaults.
// A stalled output holds the sequencer in its load state; input waits until idle.
`default_nettype none
module go_back_n_sender_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire gbn_pkg::t_in_item               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output gbn_pkg::t_out_item                   o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [gbn_pkg::CFG_W-1:0]       i_cfg_data
);
    import gbn_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CSUM   = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_RTX_RD = 3'd3;
    localparam logic [2:0] S_RTX_GO = 3'd4;

    logic [2:0]       r_state;
    t_seq             r_base;
    t_seq             r_next_seq;
    t_slot            r_base_slot;
    logic             r_timer_on;
    logic [TMO_W-1:0] r_timer_left;
    logic [WIN_W-1:0] r_window;
    logic [TMO_W-1:0] r_timeout;
    logic             r_out_valid;
    logic             r_refuse;
    t_cnt             r_idx;
    t_cnt             r_rtx_cnt;
    t_in_item         r_item;
    logic [PAY_W-1:0] r_pay;
    t_seq             r_emit_seq;
    t_out_item        r_out_data;

    t_seq             w_cnt;
    t_cnt             w_cnt_c;
    logic [CMP_W-1:0] w_effw;
    logic             w_full;
    logic             w_accept;
    logic             w_out_free;
    logic             w_last;
    t_slot            w_wr_slot;
    t_slot            w_rd_slot;
    t_seq             w_ack_d;
    logic             w_ack_ok;
    t_seq             w_new_base;
    logic [PAY_W-1:0] w_in_pay;
    logic [PAY_W-1:0] w_rdata;
    t_csum_req        w_req;
    logic             w_csum_done;
    logic [SUM_W-1:0] w_csum_sum;
    t_out_item        w_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_pay   = {i_in_data.payload_hi, i_in_data.payload_mid, i_in_data.payload_lo};

    always_comb begin
        w_cnt   = r_next_seq - r_base;
        w_cnt_c = CNT_W'(w_cnt);
        w_effw  = CMP_W'(r_window);
        if (w_effw == '0) begin
            w_effw = CMP_W'(1);
        end
        if (w_effw > CMP_W'(WIN_CAP)) begin
            w_effw = CMP_W'(WIN_CAP);
        end
        w_full     = CMP_W'(w_cnt_c) >= w_effw;
        w_wr_slot  = slot_add(r_base_slot, w_cnt_c);
        w_rd_slot  = slot_add(r_base_slot, r_idx);
        w_ack_d    = SEQ_BITS'(r_item.pkt_ack) + t_seq'(1) - r_base;
        w_ack_ok   = (w_csum_sum == r_item.pkt_checksum) && (w_ack_d != '0)
                     && (w_ack_d <= w_cnt);
        w_new_base = r_base + w_ack_d;
        w_last     = r_refuse || (r_item.kind != KIND_TICK) || (r_idx + t_cnt'(1) == r_rtx_cnt);
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.init  = SUM_W'(r_next_seq);
        w_req.data  = w_in_pay;
        if (w_accept && i_in_data.kind == KIND_MSG && !w_full) begin
            w_req.start = 1'b1;
        end else if (w_accept && i_in_data.kind == KIND_ACK) begin
            w_req.start = 1'b1;
            w_req.init  = SUM_W'(i_in_data.pkt_seq) + SUM_W'(i_in_data.pkt_ack);
        end else if (r_state == S_RTX_GO) begin
            w_req.start = 1'b1;
            w_req.init  = SUM_W'(r_base + t_seq'(r_idx));
            w_req.data  = w_rdata;
        end
    end

    always_comb begin
        w_out                 = '0;
        w_out.last            = w_last;
        if (r_refuse) begin
            w_out.status = ST_REFUSED;
        end else begin
            w_out.status          = (r_item.kind == KIND_TICK) ? ST_RETX : ST_NEW;
            w_out.seq_num         = 16'(r_emit_seq);
            w_out.sum_field       = w_csum_sum;
            w_out.out_payload_lo  = r_pay[63:0];
            w_out.out_payload_mid = r_pay[127:64];
            w_out.out_payload_hi  = r_pay[159:128];
        end
    end

    gbn_ram #(
        .WIDTH (PAY_W),
        .DEPTH (WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in_data.kind == KIND_MSG && !w_full),
        .i_waddr (w_wr_slot),
        .i_wdata (w_in_pay),
        .i_raddr (w_rd_slot),
        .o_rdata (w_rdata)
    );

    gbn_csum u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_csum_done),
        .o_sum   (w_csum_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base       <= '0;
            r_next_seq   <= '0;
            r_base_slot  <= '0;
            r_timer_on   <= 1'b0;
            r_timer_left <= '0;
            r_window     <= WINDOW_RST;
            r_timeout    <= TIMEOUT_RST;
            r_out_valid  <= 1'b0;
            r_refuse     <= 1'b0;
            r_idx        <= '0;
            r_rtx_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WINDOW:  r_window  <= i_cfg_data[WIN_W-1:0];
                    REG_TIMEOUT: r_timeout <= i_cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_refuse <= (i_in_data.kind == KIND_MSG) && w_full;
                        case (i_in_data.kind)
                            KIND_MSG: begin
                                if (w_full) begin
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_next_seq <= r_next_seq + t_seq'(1);
                                    if (w_cnt == '0) begin
                                        r_timer_on   <= 1'b1;
                                        r_timer_left <= r_timeout;
                                    end
                                    r_state <= S_CSUM;
                                end
                            end
                            KIND_ACK: begin
                                r_state <= S_CSUM;
                            end
                            KIND_TICK: begin
                                if (r_timer_on) begin
                                    if (r_timer_left > TMO_W'(1)) begin
                                        r_timer_left <= r_timer_left - TMO_W'(1);
                                    end else begin
                                        r_timer_left <= r_timeout;
                                        if (w_cnt != '0) begin
                                            r_idx     <= '0;
                                            r_rtx_cnt <= w_cnt_c;
                                            r_state   <= S_RTX_RD;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CSUM: begin
                    if (w_csum_done) begin
                        if (r_item.kind == KIND_ACK) begin
                            if (w_ack_ok) begin
                                r_base      <= w_new_base;
                                r_base_slot <= slot_add(r_base_slot, CNT_W'(w_ack_d));
                                r_timer_on  <= (w_new_base != r_next_seq);
                                r_timer_left <= (w_new_base == r_next_seq) ? '0 : r_timeout;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + t_cnt'(1);
                            r_state <= S_RTX_RD;
                        end
                    end
                end
                S_RTX_RD: r_state <= S_RTX_GO;
                S_RTX_GO: r_state <= S_CSUM;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item     <= i_in_data;
            r_pay      <= w_in_pay;
            r_emit_seq <= r_next_seq;
        end
        if (r_state == S_RTX_GO) begin
            r_pay      <= w_rdata;
            r_emit_seq <= r_base + t_seq'(r_idx);
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out_data <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_timer_needs_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_on |-> (r_next_seq != r_base))
        else $error("timer running with empty window");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (longint'(w_cnt) <= longint'(WIN_CAP)))
        else $error("outstanding count beyond window capacity");

    a_csum_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_csum_done |-> (r_state == S_CSUM))
        else $error("checksum finished outside its wait state");

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result loaded outside emit state");
`endif

endmodule
`default_nettype wire

// ===== dv/go_back_n_sender_core_tb.sv =====
// Self-checking testbench for go_back_n_sender_core: directed table and randomized
// phases, checked against an in-bench go-back-N sender model or fixed expected results.
// Depends on gbn_pkg and the go_back_n_sender_core RTL.
module go_back_n_sender_core_tb;
    import gbn_pkg::*;

    localparam int LIMIT         = 4_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 42;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [PAY_W-1:0] PAY_ZERO = '0;
    localparam logic [PAY_W-1:0] PAY_ONES = '1;
    localparam logic [PAY_W-1:0] PAY_7F   = {20{8'h7f}};
    localparam logic [PAY_W-1:0] PAY_80   = {20{8'h80}};

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_W-1:0]     cfg_val;
        logic                 fix_sum;
        logic                 has_want;
        t_in_item             it;
        t_out_item            want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    int cycles = 0;
    int fails = 0;
    int stall_left = 0;
    logic quiet = 1'b0;

    // sender model state
    logic [63:0] st_lo [WINDOW];
    logic [63:0] st_mid [WINDOW];
    logic [31:0] st_hi [WINDOW];
    logic [15:0] base_m = '0;
    logic [15:0] next_m = '0;
    logic timer_on_m = 1'b0;
    logic [15:0] left_m = '0;
    int bslot_m = 0;
    logic [WIN_W-1:0] win_m = WINDOW_RST;
    logic [TMO_W-1:0] tmo_m = TIMEOUT_RST;

    t_out_item pending_pkts[$];
    t_out_item step_pkts[$];
    t_dir_row dir_rows[$];

    go_back_n_sender_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic add_step(input t_out_item r);
        step_pkts.insert(step_pkts.size(), r);
    endtask

    task automatic add_pending(input t_out_item r);
        pending_pkts.insert(pending_pkts.size(), r);
    endtask

    task automatic add_row(input t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic logic [31:0] pkt_sum(input logic [15:0] s, input logic [15:0] a,
                                            input logic [PAY_W-1:0] pay);
        logic [31:0] acc;
        logic [7:0] b;
        acc = {16'd0, s} + {16'd0, a};
        for (int i = 0; i < 20; i++) begin
            b = pay[8*i +: 8];
            acc = acc + {{24{b[7]}}, b};
        end
        return acc;
    endfunction

    function automatic int in_flight();
        logic [15:0] d;
        d = next_m - base_m;
        return int'(d);
    endfunction

    function automatic int eff_window();
        int w;
        w = int'(win_m);
        if (w == 0) begin
            w = 1;
        end
        if (w > WINDOW) begin
            w = WINDOW;
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_out_item res_new(input logic [15:0] seq, input logic [31:0] sum,
                                          input logic [PAY_W-1:0] pay);
        t_out_item r;
        r = '0;
        r.status = ST_NEW;
        r.seq_num = seq;
        r.sum_field = sum;
        {r.out_payload_hi, r.out_payload_mid, r.out_payload_lo} = pay;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_out_item res_refused();
        t_out_item r;
        r = '0;
        r.status = ST_REFUSED;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_dir_row row_in(input logic [1:0] kind, input logic [PAY_W-1:0] pay,
                                        input logic [15:0] seq, input logic [15:0] ack,
                                        input logic [31:0] sum, input logic fix);
        t_dir_row r;
        r = '0;
        r.it.kind = kind;
        {r.it.payload_hi, r.it.payload_mid, r.it.payload_lo} = pay;
        r.it.pkt_seq = seq;
        r.it.pkt_ack = ack;
        r.it.pkt_checksum = sum;
        r.fix_sum = fix;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic t_dir_row row_chk(input t_dir_row r, input t_out_item want);
        r.has_want = 1'b1;
        r.want = want;
        return r;
    endfunction

    task automatic arm_timer();
        timer_on_m = 1'b1;
        left_m = tmo_m;
    endtask

    task automatic sender_predict(input t_in_item it);
        int cnt;
        int slot;
        logic [15:0] d;
        logic [15:0] s;
        logic [PAY_W-1:0] pay;
        t_out_item r;
        step_pkts.delete();
        pay = {it.payload_hi, it.payload_mid, it.payload_lo};
        case (it.kind)
            KIND_MSG: begin
                cnt = in_flight();
                if (cnt >= eff_window()) begin
                    add_step(res_refused());
                end else begin
                    slot = (bslot_m + cnt) % WINDOW;
                    st_lo[slot] = it.payload_lo;
                    st_mid[slot] = it.payload_mid;
                    st_hi[slot] = it.payload_hi;
                    add_step(res_new(next_m, pkt_sum(next_m, 16'd0, pay), pay));
                    if (cnt == 0) begin
                        arm_timer();
                    end
                    next_m = next_m + 16'd1;
                end
            end
            KIND_ACK: begin
                if (pkt_sum(it.pkt_seq, it.pkt_ack, pay) == it.pkt_checksum) begin
                    d = it.pkt_ack + 16'd1 - base_m;
                    if (d != 0 && int'(d) <= in_flight()) begin
                        base_m = base_m + d;
                        bslot_m = (bslot_m + int'(d)) % WINDOW;
                        if (base_m == next_m) begin
                            timer_on_m = 1'b0;
                            left_m = '0;
                        end else begin
                            arm_timer();
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (timer_on_m) begin
                    if (left_m > 16'd1) begin
                        left_m = left_m - 16'd1;
                    end else begin
                        arm_timer();
                        cnt = in_flight();
                        for (int i = 0; i < cnt; i++) begin
                            slot = (bslot_m + i) % WINDOW;
                            s = base_m + 16'(i);
                            pay = {st_hi[slot], st_mid[slot], st_lo[slot]};
                            r = res_new(s, pkt_sum(s, 16'd0, pay), pay);
                            r.status = ST_RETX;
                            r.last = (i == cnt - 1);
                            add_step(r);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input t_in_item it, input int gap, input logic typed,
                             input t_out_item typed_res);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sender_predict(it);
        if (typed) begin
            add_pending(typed_res);
        end else begin
            foreach (step_pkts[k]) add_pending(step_pkts[k]);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pkts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW) begin
            win_m = val[WIN_W-1:0];
        end else if (idx == REG_TIMEOUT) begin
            tmo_m = val[TMO_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic rand_fields(output t_in_item it);
        logic [7:0] b;
        it.kind = KIND_MSG;
        it.payload_lo = {$urandom, $urandom};
        it.payload_mid = {$urandom, $urandom};
        it.payload_hi = $urandom;
        it.pkt_seq = 16'($urandom);
        it.pkt_ack = 16'($urandom);
        it.pkt_checksum = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            b = 8'($urandom);
            {it.payload_hi, it.payload_mid, it.payload_lo} = {20{b}};
        end
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin : out_side
        t_out_item want;
        if (out_valid && out_ready) begin
            if (pending_pkts.size() == 0) begin
                fails = fails + 1;
                if (fails <= 10) begin
                    $display("unexpected packet at cycle %0d: status %0d seq %h",
                             cycles, out_data.status, out_data.seq_num);
                end
            end else begin
                want = pending_pkts.pop_front();
                if (out_data.status !== want.status || out_data.seq_num !== want.seq_num ||
                    out_data.ack_num !== want.ack_num ||
                    out_data.sum_field !== want.sum_field ||
                    out_data.out_payload_lo !== want.out_payload_lo ||
                    out_data.out_payload_mid !== want.out_payload_mid ||
                    out_data.out_payload_hi !== want.out_payload_hi ||
                    out_data.last !== want.last) begin
                    fails = fails + 1;
                    if (fails <= 10) begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected st=%0d seq=%h ack=%h sum=%h pay=%h_%h_%h last=%b",
                                 want.status, want.seq_num, want.ack_num, want.sum_field,
                                 want.out_payload_hi, want.out_payload_mid,
                                 want.out_payload_lo, want.last);
                        $display("  actual   st=%0d seq=%h ack=%h sum=%h pay=%h_%h_%h last=%b",
                                 out_data.status, out_data.seq_num, out_data.ack_num,
                                 out_data.sum_field, out_data.out_payload_hi,
                                 out_data.out_payload_mid, out_data.out_payload_lo,
                                 out_data.last);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= pick_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        t_dir_row row;
        t_in_item it;
        int r;
        int outst;
        int done;
        int wsel;
        int win_pick [4];

        win_pick = '{1, 8, 0, 15};
        foreach (st_lo[k]) begin
            st_lo[k] = '0;
            st_mid[k] = '0;
            st_hi[k] = '0;
        end

        add_row(row_chk(row_in(KIND_MSG, PAY_ZERO, 0, 0, 0, 0),
                        res_new(16'd0, 32'd0, PAY_ZERO)));
        add_row(row_chk(row_in(KIND_MSG, PAY_ONES, 0, 0, 0, 0),
                        res_new(16'd1, 32'hFFFF_FFED, PAY_ONES)));
        add_row(row_chk(row_in(KIND_MSG, PAY_7F, 0, 0, 0, 0),
                        res_new(16'd2, 32'd2542, PAY_7F)));
        add_row(row_chk(row_in(KIND_MSG, PAY_80, 0, 0, 0, 0),
                        res_new(16'd3, 32'hFFFF_F603, PAY_80)));
        add_row(row_in(KIND_MSG, {5{32'h0123_4567}}, 16'hFFFF, 16'hFFFF, '1, 0));
        add_row(row_in(KIND_MSG, {5{32'h89AB_CDEF}}, 0, 0, 0, 0));
        add_row(row_in(KIND_MSG, {10{16'h80FF}}, 0, 0, 0, 0));
        add_row(row_in(KIND_MSG, {10{16'h017F}}, 0, 0, 0, 0));
        add_row(row_chk(row_in(KIND_MSG, PAY_80, 0, 0, 0, 0), res_refused()));
        add_row(row_in(KIND_UNUSED, PAY_ONES, 16'hFFFF, 16'hFFFF, '1, 0));
        add_row(row_in(KIND_ACK, PAY_ZERO, 16'd5, 16'd1, 32'h7FFF_FFFF, 0));
        add_row(row_in(KIND_ACK, PAY_ONES, 16'hFFFF, 16'hFFFF, 0, 1));
        add_row(row_cfg(REG_TIMEOUT, 16'd0));
        add_row(row_in(KIND_ACK, PAY_7F, 16'd0, 16'd2, 0, 1));
        add_row(row_in(KIND_TICK, PAY_ZERO, 0, 0, 0, 0));
        add_row(row_cfg(REG_WINDOW, 16'hFFF0));
        add_row(row_chk(row_in(KIND_MSG, PAY_ONES, 0, 0, 0, 0), res_refused()));
        add_row(row_in(KIND_ACK, PAY_80, 16'h8000, 16'd7, 0, 1));
        add_row(row_in(KIND_ACK, PAY_ZERO, 16'd0, 16'd8, 32'h8000_0000, 0));
        add_row(row_in(KIND_TICK, PAY_ONES, 0, 0, 0, 0));
        add_row(row_chk(row_in(KIND_MSG, PAY_ZERO, 0, 0, 0, 0),
                        res_new(16'd8, 32'd8, PAY_ZERO)));
        add_row(row_chk(row_in(KIND_MSG, PAY_7F, 0, 0, 0, 0), res_refused()));
        add_row(row_cfg(REG_WINDOW, 16'd15));
        add_row(row_in(KIND_MSG, {5{32'hDEAD_BEEF}}, 0, 0, 0, 0));
        add_row(row_in(KIND_TICK, PAY_ZERO, 0, 0, 0, 0));
        add_row(row_cfg(REG_TIMEOUT, 16'hFFFF));
        add_row(row_in(KIND_ACK, PAY_ONES, 16'h1234, 16'd9, 0, 1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.is_cfg) begin
                settle();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                it = row.it;
                if (row.fix_sum) begin
                    it.pkt_checksum = pkt_sum(it.pkt_seq, it.pkt_ack,
                                              {it.payload_hi, it.payload_mid, it.payload_lo});
                end
                send_item(it, pick_gap(), row.has_want, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            wsel = (ph < 4) ? win_pick[ph] : $urandom_range(0, 15);
            write_reg(REG_WINDOW, {12'($urandom), 4'(wsel)});
            write_reg(REG_TIMEOUT, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 5)));
            quiet = (ph % 3 == 2);
            done = 0;
            while (done < PHASE_ITEMS) begin
                rand_fields(it);
                outst = in_flight();
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    it.kind = KIND_MSG;
                end else if (r < 64) begin
                    it.kind = KIND_ACK;
                    if (outst > 0) begin
                        it.pkt_ack = base_m + 16'($urandom_range(0, outst - 1));
                    end else begin
                        it.pkt_ack = base_m - 16'd1;
                    end
                    it.pkt_checksum = pkt_sum(it.pkt_seq, it.pkt_ack,
                                              {it.payload_hi, it.payload_mid, it.payload_lo});
                end else if (r < 88) begin
                    it.kind = KIND_TICK;
                end else if (r < 94) begin
                    it.kind = KIND_ACK;
                    it.pkt_ack = base_m + 16'($urandom_range(0, 8));
                    it.pkt_checksum = pkt_sum(it.pkt_seq, it.pkt_ack,
                                              {it.payload_hi, it.payload_mid, it.payload_lo})
                                      ^ (32'd1 << $urandom_range(0, 31));
                end else if (r < 97) begin
                    it.kind = KIND_ACK;
                    if ($urandom_range(0, 1) == 0) begin
                        it.pkt_ack = base_m - 16'd1;
                    end else begin
                        it.pkt_ack = base_m + 16'(outst) + 16'($urandom_range(0, 65000));
                    end
                    it.pkt_checksum = pkt_sum(it.pkt_seq, it.pkt_ack,
                                              {it.payload_hi, it.payload_mid, it.payload_lo});
                end else begin
                    it.kind = KIND_UNUSED;
                end
                send_item(it, pick_gap(), 1'b0, '0);
                done++;
            end
        end

        quiet = 1'b0;
        settle();
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
